### rtl/euler_vector_rotation_defines.svh
// Assertion macros for the Euler point rotation block.
`ifndef EULER_VECTOR_ROTATION_DEFINES_SVH
`define EULER_VECTOR_ROTATION_DEFINES_SVH
`ifndef NO_ASSERTIONS
// checked while out of reset
`define EVR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define EVR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EVR_ASSERT(label, prop, msg)
`define EVR_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

### rtl/evr_pkg.sv
// Shared constants and the arctangent table for the Euler point rotation block.
`timescale 1ns / 1ps
package evr_pkg;
  localparam int COORD_W = 24;
  localparam int ANGLE_W = 16;
  localparam int TRIG_W = 18;
  localparam int Z_W = 26;
  localparam int CX_W = 31;
  localparam int CORDIC_STAGES = 10;
  localparam int ANGLE_LAT = 3;
  localparam int TRIG_LAT = ANGLE_LAT + CORDIC_STAGES + 1;
  localparam int ROT_LAT = 2;
  localparam int LAT = TRIG_LAT + 3 * ROT_LAT;

  localparam logic [1:0] DIR_POS = 2'b01;
  localparam logic [1:0] DIR_NEG = 2'b11;
  localparam logic [1:0] DIR_NEG2 = 2'b10;

  localparam logic signed [CX_W-1:0] CORDIC_GAIN = 31'sd163008218;

  // atan(2^-i) in degrees * 65536
  function automatic logic signed [Z_W-1:0] atan_deg(input int idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0: v = 26'sd2949120;
      1: v = 26'sd1740967;
      2: v = 26'sd919879;
      3: v = 26'sd466945;
      4: v = 26'sd234379;
      5: v = 26'sd117304;
      6: v = 26'sd58666;
      7: v = 26'sd29335;
      8: v = 26'sd14668;
      9: v = 26'sd7334;
      10: v = 26'sd3667;
      11: v = 26'sd1833;
      12: v = 26'sd917;
      13: v = 26'sd458;
      14: v = 26'sd229;
      15: v = 26'sd115;
      16: v = 26'sd57;
      17: v = 26'sd29;
      18: v = 26'sd14;
      19: v = 26'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage

### rtl/evr_angle.sv
// Angle scaling, reduction modulo a full turn and quadrant fold (three stages).
`timescale 1ns / 1ps
module evr_angle (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [evr_pkg::ANGLE_W-1:0]  angle,
  input  logic signed [1:0]                   dir_sign,
  input  logic                                invert,
  output logic signed [evr_pkg::Z_W-1:0]      z,
  output logic                                neg
);
  localparam logic [17:0] T1 = 18'd23040;
  localparam logic [17:0] T2 = 18'd46080;
  localparam logic [17:0] T4 = 18'd92160;
  localparam logic signed [15:0] FULL = 16'sd23040;
  localparam logic signed [15:0] HALF = 16'sd11520;
  localparam logic signed [15:0] QUARTER = 16'sd5760;

  logic signed [17:0] a18, prod, eff;
  logic signed [18:0] biased;
  logic [17:0] v;
  logic [17:0] t1, t2, t3;
  logic [14:0] r;
  logic signed [15:0] s0, s1;
  logic neg_next;

  assign a18 = {{2{angle[15]}}, angle};

  always_comb begin
    case (dir_sign)
      evr_pkg::DIR_POS:  prod = a18;
      evr_pkg::DIR_NEG:  prod = -a18;
      evr_pkg::DIR_NEG2: prod = -(a18 <<< 1);
      default:           prod = '0;
    endcase
    eff = invert ? -prod : prod;
    // shift into the non-negative range before the modulo
    biased = 19'(eff) + 19'sd92160;
  end

  always_comb begin
    t1 = (v >= T4) ? v - T4 : v;
    t2 = (t1 >= T2) ? t1 - T2 : t1;
    t3 = (t2 >= T1) ? t2 - T1 : t2;
  end

  always_comb begin
    s0 = $signed({1'b0, r});
    if (s0 >= HALF) begin
      s0 = s0 - FULL;
    end
    s1 = s0;
    neg_next = 1'b0;
    if (s0 > QUARTER) begin
      s1 = s0 - HALF;
      neg_next = 1'b1;
    end else if (s0 < -QUARTER) begin
      s1 = s0 + HALF;
      neg_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v <= biased[17:0];
      r <= t3[14:0];
      z <= {{10{s1[15]}}, s1} <<< 10;
      neg <= neg_next;
    end
  end
endmodule

### rtl/evr_cordic.sv
// Pipelined rotation-mode CORDIC, two iterations per stage, then Q16 rounding.
`timescale 1ns / 1ps
module evr_cordic (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [evr_pkg::Z_W-1:0]     z_in,
  input  logic                               neg_in,
  output logic signed [evr_pkg::TRIG_W-1:0]  sin_out,
  output logic signed [evr_pkg::TRIG_W-1:0]  cos_out
);
  localparam int N = evr_pkg::CORDIC_STAGES;
  localparam int XW = evr_pkg::CX_W;
  localparam int ZW = evr_pkg::Z_W;

  logic signed [XW-1:0] xr [N];
  logic signed [XW-1:0] yr [N];
  logic signed [ZW-1:0] zr [N];
  logic                 nr [N];

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_stage
      localparam int I0 = 2 * k;
      localparam int I1 = 2 * k + 1;
      logic signed [XW-1:0] px, py, x1, y1, x2, y2;
      logic signed [ZW-1:0] pz, z1, z2;
      logic pn;
      if (k == 0) begin : g_first
        assign px = evr_pkg::CORDIC_GAIN;
        assign py = '0;
        assign pz = z_in;
        assign pn = neg_in;
      end else begin : g_next
        assign px = xr[k-1];
        assign py = yr[k-1];
        assign pz = zr[k-1];
        assign pn = nr[k-1];
      end
      always_comb begin
        if (pz >= 0) begin
          x1 = px - (py >>> I0);
          y1 = py + (px >>> I0);
          z1 = pz - evr_pkg::atan_deg(I0);
        end else begin
          x1 = px + (py >>> I0);
          y1 = py - (px >>> I0);
          z1 = pz + evr_pkg::atan_deg(I0);
        end
        if (z1 >= 0) begin
          x2 = x1 - (y1 >>> I1);
          y2 = y1 + (x1 >>> I1);
          z2 = z1 - evr_pkg::atan_deg(I1);
        end else begin
          x2 = x1 + (y1 >>> I1);
          y2 = y1 - (x1 >>> I1);
          z2 = z1 + evr_pkg::atan_deg(I1);
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          xr[k] <= x2;
          yr[k] <= y2;
          zr[k] <= z2;
          nr[k] <= pn;
        end
      end
    end
  endgenerate

  logic signed [XW-1:0] xs, ys;
  logic signed [evr_pkg::TRIG_W-1:0] cq, sq;

  always_comb begin
    xs = (xr[N-1] + 31'sd2048) >>> 12;
    ys = (yr[N-1] + 31'sd2048) >>> 12;
    if (xs > 31'sd65536) cq = 18'sd65536;
    else if (xs < -31'sd65536) cq = -18'sd65536;
    else cq = xs[evr_pkg::TRIG_W-1:0];
    if (ys > 31'sd65536) sq = 18'sd65536;
    else if (ys < -31'sd65536) sq = -18'sd65536;
    else sq = ys[evr_pkg::TRIG_W-1:0];
    if (nr[N-1]) begin
      cq = -cq;
      sq = -sq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_out <= sq;
      cos_out <= cq;
    end
  end
endmodule

### rtl/evr_rotate.sv
// One planar rotation: products registered, then round, shift and saturate.
`timescale 1ns / 1ps
module evr_rotate (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [evr_pkg::COORD_W-1:0] a,
  input  logic signed [evr_pkg::COORD_W-1:0] b,
  input  logic signed [evr_pkg::TRIG_W-1:0]  c,
  input  logic signed [evr_pkg::TRIG_W-1:0]  s,
  output logic signed [evr_pkg::COORD_W-1:0] na,
  output logic signed [evr_pkg::COORD_W-1:0] nb
);
  logic signed [41:0] ac, bs, bc, as_p;
  logic signed [42:0] sa, sb, ha, hb;
  logic signed [evr_pkg::COORD_W-1:0] na_next, nb_next;

  always_comb begin
    sa = 43'(ac) - 43'(bs) + 43'sd32768;
    sb = 43'(bc) + 43'(as_p) + 43'sd32768;
    ha = sa >>> 16;
    hb = sb >>> 16;
    if (ha > 43'sd8388607) na_next = 24'sh7FFFFF;
    else if (ha < -43'sd8388608) na_next = 24'sh800000;
    else na_next = ha[evr_pkg::COORD_W-1:0];
    if (hb > 43'sd8388607) nb_next = 24'sh7FFFFF;
    else if (hb < -43'sd8388608) nb_next = 24'sh800000;
    else nb_next = hb[evr_pkg::COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ac <= 42'(a) * 42'(c);
      bs <= 42'(b) * 42'(s);
      bc <= 42'(b) * 42'(c);
      as_p <= 42'(a) * 42'(s);
      na <= na_next;
      nb <= nb_next;
    end
  end
endmodule

### rtl/euler_vector_rotation.sv
// Top level: Euler-angle rotation of a 3D point, pitch then yaw then roll.
// Request to result: angle reduction, CORDIC stages, a rounding register, then the three axis rotations in turn.
// Throughput: one request per cycle; the whole pipeline advances unless the result is stalled.
// The three CORDIC pipelines run in parallel; each axis rotation uses four 24x18 multipliers.
// Reset clears only the stage valid bits; payload registers hold whatever they had.
`timescale 1ns / 1ps
`include "euler_vector_rotation_defines.svh"
module euler_vector_rotation (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [evr_pkg::COORD_W-1:0] point_x,
  input  logic signed [evr_pkg::COORD_W-1:0] point_y,
  input  logic signed [evr_pkg::COORD_W-1:0] point_z,
  input  logic signed [evr_pkg::ANGLE_W-1:0] angle_pitch,
  input  logic signed [evr_pkg::ANGLE_W-1:0] angle_yaw,
  input  logic signed [evr_pkg::ANGLE_W-1:0] angle_roll,
  input  logic signed [1:0]                  dir_sign,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [evr_pkg::COORD_W-1:0] out_x,
  output logic signed [evr_pkg::COORD_W-1:0] out_y,
  output logic signed [evr_pkg::COORD_W-1:0] out_z
);
  localparam int L = evr_pkg::LAT;
  localparam int TL = evr_pkg::TRIG_LAT;
  localparam int CW = evr_pkg::COORD_W;
  localparam int TW = evr_pkg::TRIG_W;

  logic en;
  logic [L-1:0] vld;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-2:0], in_valid};
    end
  end

  // angle and trig pipelines
  logic signed [evr_pkg::Z_W-1:0] zp, zy, zr;
  logic np, ny, nr;
  logic signed [TW-1:0] sp, cp, sy, cy, sr, cr;

  evr_angle u_ang_p (.clk, .en, .angle(angle_pitch), .dir_sign, .invert(1'b1), .z(zp), .neg(np));
  evr_angle u_ang_y (.clk, .en, .angle(angle_yaw), .dir_sign, .invert(1'b0), .z(zy), .neg(ny));
  evr_angle u_ang_r (.clk, .en, .angle(angle_roll), .dir_sign, .invert(1'b0), .z(zr), .neg(nr));

  evr_cordic u_cor_p (.clk, .en, .z_in(zp), .neg_in(np), .sin_out(sp), .cos_out(cp));
  evr_cordic u_cor_y (.clk, .en, .z_in(zy), .neg_in(ny), .sin_out(sy), .cos_out(cy));
  evr_cordic u_cor_r (.clk, .en, .z_in(zr), .neg_in(nr), .sin_out(sr), .cos_out(cr));

  // point delay line matches the trig latency
  logic signed [CW-1:0] dx [TL];
  logic signed [CW-1:0] dy [TL];
  logic signed [CW-1:0] dz [TL];

  always_ff @(posedge clk) begin
    if (en) begin
      dx[0] <= point_x;
      dy[0] <= point_y;
      dz[0] <= point_z;
      for (int i = 1; i < TL; i++) begin
        dx[i] <= dx[i-1];
        dy[i] <= dy[i-1];
        dz[i] <= dz[i-1];
      end
    end
  end

  // trig for later axes and pass-through coordinates wait for the earlier rotations
  logic signed [TW-1:0] sy_d [2];
  logic signed [TW-1:0] cy_d [2];
  logic signed [TW-1:0] sr_d [4];
  logic signed [TW-1:0] cr_d [4];
  logic signed [CW-1:0] y_pass [2];
  logic signed [CW-1:0] z_pass [2];
  logic signed [CW-1:0] x_pass [2];
  logic signed [CW-1:0] x1, z1, y2, x2, z3, y3;

  always_ff @(posedge clk) begin
    if (en) begin
      sy_d[0] <= sy;
      sy_d[1] <= sy_d[0];
      cy_d[0] <= cy;
      cy_d[1] <= cy_d[0];
      sr_d[0] <= sr;
      cr_d[0] <= cr;
      for (int i = 1; i < 4; i++) begin
        sr_d[i] <= sr_d[i-1];
        cr_d[i] <= cr_d[i-1];
      end
      y_pass[0] <= dy[TL-1];
      y_pass[1] <= y_pass[0];
      z_pass[0] <= z1;
      z_pass[1] <= z_pass[0];
      x_pass[0] <= x2;
      x_pass[1] <= x_pass[0];
    end
  end

  evr_rotate u_rot_p (.clk, .en, .a(dx[TL-1]), .b(dz[TL-1]), .c(cp), .s(sp), .na(x1), .nb(z1));
  evr_rotate u_rot_y (.clk, .en, .a(y_pass[1]), .b(x1), .c(cy_d[1]), .s(sy_d[1]),
                      .na(y2), .nb(x2));
  evr_rotate u_rot_r (.clk, .en, .a(z_pass[1]), .b(y2), .c(cr_d[3]), .s(sr_d[3]),
                      .na(z3), .nb(y3));

  assign out_x = x_pass[1];
  assign out_y = y3;
  assign out_z = z3;

  `EVR_ASSERT(a_stall_freezes, (out_valid && out_stall) |=> $stable(vld), "pipeline moved while stalled")
  `EVR_ASSERT(a_request_enters, (in_valid && !in_stall) |=> vld[0], "accepted request not in first stage")
  `EVR_ASSERT(a_bubble_enters, (!in_valid && !in_stall) |=> !vld[0], "bubble became valid")
endmodule

### dv/tb_top.sv
// Self-checking testbench for the Euler-angle point rotation block.
`timescale 1ns / 1ps
module tb_top;
  localparam int N_RANDOM = 930;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] DIR_ZERO = 2'b00;

  typedef struct packed {
    logic signed [evr_pkg::COORD_W-1:0] x;
    logic signed [evr_pkg::COORD_W-1:0] y;
    logic signed [evr_pkg::COORD_W-1:0] z;
  } point_t;

  int mismatches = 0;

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  class rotation_scoreboard;
    point_t pending[$];

    static function longint floor_shr(longint v, int s);
      return v >>> s;
    endfunction

    static function longint sat24(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
    endfunction

    static function longint clamp_unit(longint v);
      if (v > 65536) return 65536;
      if (v < -65536) return -65536;
      return v;
    endfunction

    // angle in 1/64 degree, outputs Q16
    static function void trig(longint angle, output longint sn, output longint cs);
      longint r, x, y, z, t, dx, dy;
      bit flip;
      r = angle % 23040;
      flip = 0;
      if (r < 0) r += 23040;
      if (r >= 11520) r -= 23040;
      if (r > 5760) begin
        r -= 11520; flip = 1;
      end else if (r < -5760) begin
        r += 11520; flip = 1;
      end
      x = 163008218; y = 0; z = r * 1024;
      for (int i = 0; i < 20; i++) begin
        dx = floor_shr(y, i);
        dy = floor_shr(x, i);
        if (z >= 0) begin
          t = x - dx; y = y + dy; z -= evr_pkg::atan_deg(i);
        end else begin
          t = x + dx; y = y - dy; z += evr_pkg::atan_deg(i);
        end
        x = t;
      end
      x = clamp_unit(floor_shr(x + 2048, 12));
      y = clamp_unit(floor_shr(y + 2048, 12));
      if (flip) begin
        x = -x; y = -y;
      end
      sn = y; cs = x;
    endfunction

    function void note_request(point_t p, logic signed [evr_pkg::ANGLE_W-1:0] pitch,
                               logic signed [evr_pkg::ANGLE_W-1:0] yaw,
                               logic signed [evr_pkg::ANGLE_W-1:0] roll,
                               logic signed [1:0] dir);
      longint c[3], ang[3], sn[3], cs[3], a, b, na, nb;
      int j;
      c[0] = p.x; c[1] = p.y; c[2] = p.z;
      ang[0] = -longint'(dir) * longint'(pitch);
      ang[1] = longint'(dir) * longint'(yaw);
      ang[2] = longint'(dir) * longint'(roll);
      for (int i = 0; i < 3; i++) trig(ang[i], sn[i], cs[i]);
      // pitch on (x,z), yaw on (y,x), roll on (z,y)
      for (int i = 0; i < 3; i++) begin
        j = (i + 2) % 3;
        a = c[i]; b = c[j];
        na = a * cs[i] - b * sn[i];
        nb = b * cs[i] + a * sn[i];
        c[i] = sat24(floor_shr(na + 32768, 16));
        c[j] = sat24(floor_shr(nb + 32768, 16));
      end
      pending.push_back('{x: c[0][23:0], y: c[1][23:0], z: c[2][23:0]});
    endfunction

    task check_result(point_t got);
      point_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d %0d %0d", got.x, got.y, got.z));
        return;
      end
      want = pending.pop_front();
      if (got.x !== want.x) report_mismatch($sformatf("out_x %0d want %0d", got.x, want.x));
      if (got.y !== want.y) report_mismatch($sformatf("out_y %0d want %0d", got.y, want.y));
      if (got.z !== want.z) report_mismatch($sformatf("out_z %0d want %0d", got.z, want.z));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [evr_pkg::COORD_W-1:0] point_x = '0, point_y = '0, point_z = '0;
  logic signed [evr_pkg::ANGLE_W-1:0] angle_pitch = '0, angle_yaw = '0, angle_roll = '0;
  logic signed [1:0] dir_sign = evr_pkg::DIR_POS;
  logic out_valid;
  logic out_stall = 0;
  logic signed [evr_pkg::COORD_W-1:0] out_x, out_y, out_z;

  rotation_scoreboard rot_sb = new();
  int cycle_count = 0;
  bit quiet_tail = 0;

  always #5 clk = ~clk;

  euler_vector_rotation i_dut (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: accept and check, with random stall bursts
  initial begin : result_side
    int burst;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall)
        rot_sb.check_result('{x: out_x, y: out_y, z: out_z});
      if (burst > 0) begin
        burst--;
        if (burst == 0) out_stall <= 0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 17);
        out_stall <= 1;
      end
    end
  end

  function automatic logic signed [evr_pkg::ANGLE_W-1:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 46080)) - 16'sd23040;
      1: return 16'(($urandom_range(0, 8) * 2880) - 11520);
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 11520)) - 16'sd5760;
    endcase
  endfunction

  function automatic logic signed [evr_pkg::COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      default: return 24'($signed($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  function automatic logic [1:0] pick_dir();
    case ($urandom_range(0, 7))
      0: return evr_pkg::DIR_NEG2;
      1: return DIR_ZERO;
      2, 3, 4: return evr_pkg::DIR_NEG;
      default: return evr_pkg::DIR_POS;
    endcase
  endfunction

  // one request: wait for acceptance, note it, then maybe pause
  task automatic send_point(point_t p, logic signed [evr_pkg::ANGLE_W-1:0] pitch,
                            logic signed [evr_pkg::ANGLE_W-1:0] yaw,
                            logic signed [evr_pkg::ANGLE_W-1:0] roll, logic [1:0] dir);
    in_valid <= 1;
    point_x <= p.x; point_y <= p.y; point_z <= p.z;
    angle_pitch <= pitch; angle_yaw <= yaw; angle_roll <= roll;
    dir_sign <= dir;
    do @(posedge clk); while (in_stall);
    rot_sb.note_request(p, pitch, yaw, roll, dir);
    if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    point_t p;
    logic signed [evr_pkg::ANGLE_W-1:0] corner[6];
    corner = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd5760, -16'sd11520, 16'sh7fff};
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: field extremes, each direction code, right angles, wraps
    foreach (corner[k])
      send_point('{24'sh7fffff, 24'sh800000, 24'sd256}, corner[k], corner[(k + 1) % 6],
                 corner[(k + 2) % 6], evr_pkg::DIR_POS);
    send_point('{24'sh7fffff, 24'sh7fffff, 24'sh7fffff}, 16'sd2880, 16'sd2880, 16'sd2880,
               evr_pkg::DIR_NEG);
    send_point('{24'sh800000, 24'sh800000, 24'sh800000}, 16'sd2880, -16'sd2880, 16'sd2880,
               evr_pkg::DIR_NEG2);
    send_point('{24'sd1000, -24'sd1000, 24'sd77}, 16'sd1234, 16'sd999, -16'sd4000, DIR_ZERO);
    send_point('{24'sd0, 24'sd0, 24'sd0}, 16'sh8000, 16'sh8000, 16'sh8000, evr_pkg::DIR_NEG2);
    send_point('{24'sd65536, 24'sd0, 24'sd0}, 16'sd5760, 16'sd0, 16'sd0, evr_pkg::DIR_POS);
    send_point('{24'sd0, 24'sd65536, 24'sd0}, 16'sd0, 16'sd11520, 16'sd0, evr_pkg::DIR_NEG);
    send_point('{24'sd0, 24'sd0, 24'sd65536}, 16'sd0, 16'sd0, 16'sd28800, evr_pkg::DIR_POS);
    send_point('{24'sd5555, 24'sd4444, 24'sd3333}, 16'sd5761, -16'sd5761, 16'sd17280,
               evr_pkg::DIR_NEG2);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        // let the pipeline drain fully before continuing
        in_valid <= 0;
        wait (rot_sb.pending.size() == 0);
        @(posedge clk);
      end
      if (n == N_RANDOM - 150) quiet_tail = 1;
      p = '{pick_coord(), pick_coord(), pick_coord()};
      send_point(p, pick_angle(), pick_angle(), pick_angle(), pick_dir());
    end
    in_valid <= 0;
    wait (rot_sb.pending.size() == 0);
    repeat (evr_pkg::LAT + 10) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule
